FILE: hw/rtl/tdmsa_pkg.sv
`default_nettype none

package tdmsa_pkg;

    localparam int TIMESLOTS = 32;
    localparam int SUBSLOTS  = 15;
    localparam int MAX_EP    = TIMESLOTS * SUBSLOTS;

    localparam int IDX_W  = 9;                      // endpoint index, counts
    localparam int TSQ_W  = 6;                      // quotient of a 9-bit value by 15
    localparam int SS_W   = 4;
    localparam int MUL_W  = 10;                     // timeslot * 15
    localparam int TS_W   = (TIMESLOTS > 1) ? $clog2(TIMESLOTS) : 1;
    localparam int CIDX_W = 2;
    localparam int CDAT_W = 9;

    // 2^15 / 15 rounded up; exact floor for every 9-bit dividend
    localparam int RECIP15 = 2185;
    localparam int RSHIFT  = 15;

    localparam logic [CIDX_W-1:0] CFG_TRUNK_MODE = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_EP_COUNT   = 2'd1;

    typedef enum logic [1:0] {
        KIND_ALLOC   = 2'd0,
        KIND_CLAIM   = 2'd1,
        KIND_RELEASE = 2'd2,
        KIND_UNUSED  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NO_FREE   = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_TS_ZERO   = 2'd3
    } status_t;

    typedef struct packed {
        kind_t             kind;
        logic [IDX_W-1:0]  endpoint_index;
    } req_t;

    typedef struct packed {
        status_t           status;
        logic [IDX_W-1:0]  granted_index;
        logic [IDX_W-1:0]  used_count;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_CHECK,
        ST_SCAN,
        ST_UPDATE,
        ST_RESP
    } state_t;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_FIRST,
        RD_NEXT,
        RD_LOOKUP
    } rd_sel_t;

    typedef enum logic [1:0] {
        GR_ZERO,
        GR_IDX,
        GR_SCAN
    } gr_sel_t;

    typedef struct packed {
        logic     capture;
        logic     decode;
        rd_sel_t  rd_sel;
        logic     commit;
        logic     set_res;
        status_t  res_status;
        gr_sel_t  gr_sel;
        logic     load_out;
    } cmd_t;

    typedef struct packed {
        kind_t  kind;
        logic   cnt_zero;
        logic   idx_absent;
        logic   ts_zero_e1;
        logic   hit;
        logic   scan_last;
        logic   out_free;
    } sts_t;

    // overlapping subslots of each subslot in the 64k/32k/16k/8k tree
    localparam logic [SUBSLOTS-1:0] OVERLAP [SUBSLOTS] = '{
        15'h7FFE, 15'h0799, 15'h7861, 15'h0183, 15'h0603, 15'h1805, 15'h6005,
        15'h000B, 15'h000B, 15'h0013, 15'h0013, 15'h0025, 15'h0025,
        15'h0045, 15'h0045
    };

    function automatic logic [TSQ_W-1:0] div15(input logic [IDX_W-1:0] x);
        logic [IDX_W+12-1:0] prod;
        prod = (IDX_W+12)'(x) * (IDX_W+12)'(RECIP15);
        return prod[RSHIFT +: TSQ_W];
    endfunction

    function automatic logic [MUL_W-1:0] mul15(input logic [TSQ_W-1:0] x);
        return (MUL_W'(x) << 4) - MUL_W'(x);
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tdm_subslot_endpoint_allocator.sv
// Channel | Dir | Handshake             | Payload
// in      | in  | in_valid / in_ready   | req_t: kind, endpoint_index
// out     | out | out_valid / out_ready | rsp_t: status, granted_index, used_count
// cfg     | in  | cfg_valid / cfg_ready | cfg_index (0 trunk_mode, 1 endpoint_count), cfg_data
//
// One request at a time. Claim and release go through decode, check, update and
// response before the next accept; rejected requests go from check straight to
// response. Allocate scans one timeslot word a cycle from the busy RAM (registered
// read, next read issued while the current word is checked), up to all 32 timeslots.
// Reset clears per-timeslot valid bits at once; no clearing pass, the block takes
// a request straight after reset. A result waiting in the output register does
// not stop the next request being taken; it only holds the block before its own
// response is loaded. cfg_ready is always high.
`default_nettype none

module tdm_subslot_endpoint_allocator (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire tdmsa_pkg::req_t                in_data,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output tdmsa_pkg::rsp_t                     out_data,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [tdmsa_pkg::CIDX_W-1:0]   cfg_index,
    input  wire logic [tdmsa_pkg::CDAT_W-1:0]   cfg_data
);

    import tdmsa_pkg::*;

    // controller drives the datapath through one command word and reads
    // back a status word; nothing else crosses between them
    cmd_t cmd;
    sts_t sts;

    tdmsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: config registers, busy-map RAM with valid bits, scan
    // priority encoder, claimed counter and the output register
    tdmsa_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/tdmsa_ram.sv
`default_nettype none

module tdmsa_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 32
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic                                      re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/tdmsa_ctrl.sv
`default_nettype none

module tdmsa_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire tdmsa_pkg::sts_t sts,
    output tdmsa_pkg::cmd_t      cmd
);

    import tdmsa_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.rd_sel     = RD_NONE;
        cmd.res_status = STAT_OK;
        cmd.gr_sel     = GR_ZERO;
        in_ready       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                cmd.decode = 1'b1;
                state_next = ST_CHECK;
            end

            ST_CHECK:
            begin
                priority if (sts.kind == KIND_ALLOC)
                begin
                    if (sts.cnt_zero)
                    begin
                        cmd.set_res    = 1'b1;
                        cmd.res_status = STAT_NO_FREE;
                        state_next     = ST_RESP;
                    end
                    else
                    begin
                        cmd.rd_sel = RD_FIRST;
                        state_next = ST_SCAN;
                    end
                end
                else if (sts.kind == KIND_UNUSED || sts.idx_absent)
                begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = STAT_NOT_FOUND;
                    state_next     = ST_RESP;
                end
                else if (sts.kind == KIND_CLAIM && sts.ts_zero_e1)
                begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = STAT_TS_ZERO;
                    state_next     = ST_RESP;
                end
                else
                begin
                    cmd.rd_sel = RD_LOOKUP;
                    state_next = ST_UPDATE;
                end
            end

            ST_SCAN:
            begin
                priority if (sts.hit)
                begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = STAT_OK;
                    cmd.gr_sel     = GR_SCAN;
                    state_next     = ST_RESP;
                end
                else if (sts.scan_last)
                begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = STAT_NO_FREE;
                    state_next     = ST_RESP;
                end
                else
                begin
                    cmd.rd_sel = RD_NEXT;
                end
            end

            ST_UPDATE:
            begin
                cmd.commit     = 1'b1;
                cmd.set_res    = 1'b1;
                cmd.res_status = STAT_OK;
                cmd.gr_sel     = GR_IDX;
                state_next     = ST_RESP;
            end

            ST_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // a scan ends in a response, never in a write-back
    a_scan_exit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |=> state_reg == ST_SCAN || state_reg == ST_RESP)
        else $error("scan left for a state other than response");

endmodule

`default_nettype wire

FILE: hw/rtl/tdmsa_dp.sv
`default_nettype none

module tdmsa_dp (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire tdmsa_pkg::req_t                    in_data,
    output tdmsa_pkg::rsp_t                         out_data,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [tdmsa_pkg::CIDX_W-1:0]       cfg_index,
    input  wire logic [tdmsa_pkg::CDAT_W-1:0]       cfg_data,
    input  wire tdmsa_pkg::cmd_t                    cmd,
    output tdmsa_pkg::sts_t                         sts
);

    import tdmsa_pkg::*;

    // configuration and control state
    logic                  mode_reg;
    logic [IDX_W-1:0]      count_reg;
    logic [IDX_W-1:0]      claimed_reg, claimed_next;
    logic [TIMESLOTS-1:0]  vld_reg;
    logic                  rd_vld_reg, rd_vld_next;
    logic                  out_valid_reg;

    // payload
    kind_t                 kind_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [TSQ_W-1:0]      ts_reg;
    logic [TSQ_W-1:0]      last_ts_reg;
    logic [TS_W-1:0]       scan_ts_reg, scan_ts_next;
    status_t               res_status_reg;
    logic [IDX_W-1:0]      res_idx_reg, res_idx_next;
    rsp_t                  out_data_reg;

    logic [IDX_W-1:0]      eff_cnt;
    logic                  re;
    logic [TS_W-1:0]       raddr;
    logic [SUBSLOTS-1:0]   ram_q;
    logic [SUBSLOTS-1:0]   word;
    logic [MUL_W-1:0]      scan_base;
    logic [MUL_W-1:0]      rem_cnt;
    logic [SUBSLOTS-1:0]   present;
    logic [SUBSLOTS-1:0]   free_vec;
    logic                  hit;
    logic [SS_W-1:0]       hit_ss;
    logic [SS_W-1:0]       ss;
    logic [SUBSLOTS-1:0]   ss_bit;
    logic                  cur_busy;
    logic                  we;
    logic [SUBSLOTS-1:0]   wdata;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (32'(count_reg) > MAX_EP)
        begin
            eff_cnt = IDX_W'(MAX_EP);
        end
        else
        begin
            eff_cnt = count_reg;
        end
    end

    // read port select
    always_comb
    begin
        re           = 1'b1;
        raddr        = '0;
        scan_ts_next = scan_ts_reg;
        unique case (cmd.rd_sel)
            RD_NONE:
            begin
                re = 1'b0;
            end
            RD_FIRST:
            begin
                scan_ts_next = '0;
            end
            RD_NEXT:
            begin
                raddr        = scan_ts_reg + 1'b1;
                scan_ts_next = scan_ts_reg + 1'b1;
            end
            RD_LOOKUP:
            begin
                raddr = ts_reg[TS_W-1:0];
            end
            default:
            begin
                re = 1'b0;
            end
        endcase
        rd_vld_next = rd_vld_reg;
        if (re)
        begin
            rd_vld_next = (32'(raddr) < TIMESLOTS) && vld_reg[raddr];
        end
    end

    tdmsa_ram #(
        .WIDTH (SUBSLOTS),
        .DEPTH (TIMESLOTS)
    ) u_busy_ram (
        .clk   (clk),
        .we    (we),
        .waddr (ts_reg[TS_W-1:0]),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (ram_q)
    );

    // never-written timeslots read as all free
    assign word = rd_vld_reg ? ram_q : '0;

    // scan: first free present subslot, with overlap interlock on E1
    always_comb
    begin
        scan_base = mul15(TSQ_W'(scan_ts_reg));
        rem_cnt   = MUL_W'(eff_cnt) - scan_base;
        if (rem_cnt >= MUL_W'(SUBSLOTS))
        begin
            present = '1;
        end
        else
        begin
            present = SUBSLOTS'((16'(1) << rem_cnt[SS_W-1:0]) - 16'(1));
        end
        for (int s = 0; s < SUBSLOTS; s++)
        begin
            free_vec[s] = !word[s] && present[s]
                          && !(mode_reg && ((word & present & OVERLAP[s]) != '0));
        end
        hit    = 1'b0;
        hit_ss = '0;
        for (int s = SUBSLOTS - 1; s >= 0; s--)
        begin
            if (free_vec[s])
            begin
                hit    = 1'b1;
                hit_ss = SS_W'(s);
            end
        end
    end

    // claim / release write-back
    always_comb
    begin
        ss       = SS_W'(MUL_W'(idx_reg) - mul15(ts_reg));
        ss_bit   = SUBSLOTS'(1) << ss;
        cur_busy = (word & ss_bit) != '0;
        we       = 1'b0;
        wdata    = word;
        claimed_next = claimed_reg;
        if (cmd.commit)
        begin
            if (kind_reg == KIND_CLAIM)
            begin
                wdata = word | ss_bit;
                if (!cur_busy)
                begin
                    we           = 1'b1;
                    claimed_next = claimed_reg + 1'b1;
                end
            end
            else
            begin
                wdata = word & ~ss_bit;
                if (cur_busy)
                begin
                    we = 1'b1;
                    if (claimed_reg != '0)
                    begin
                        claimed_next = claimed_reg - 1'b1;
                    end
                end
            end
        end
    end

    always_comb
    begin
        unique case (cmd.gr_sel)
            GR_ZERO: res_idx_next = '0;
            GR_IDX:  res_idx_next = idx_reg;
            GR_SCAN: res_idx_next = IDX_W'(scan_base + MUL_W'(hit_ss));
            default: res_idx_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            count_reg     <= IDX_W'(480);
            claimed_reg   <= '0;
            vld_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_index == CFG_TRUNK_MODE)
            begin
                mode_reg <= cfg_data[0];
            end
            if (cfg_valid && cfg_index == CFG_EP_COUNT)
            begin
                count_reg <= cfg_data[IDX_W-1:0];
            end
            claimed_reg <= claimed_next;
            rd_vld_reg  <= rd_vld_next;
            if (we)
            begin
                vld_reg[ts_reg[TS_W-1:0]] <= 1'b1;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= in_data.kind;
            idx_reg  <= in_data.endpoint_index;
        end
        if (cmd.decode)
        begin
            ts_reg      <= div15(idx_reg);
            last_ts_reg <= div15(IDX_W'(eff_cnt - 1'b1));
        end
        scan_ts_reg <= scan_ts_next;
        if (cmd.set_res)
        begin
            res_status_reg <= cmd.res_status;
            res_idx_reg    <= res_idx_next;
        end
        if (cmd.load_out)
        begin
            out_data_reg.status        <= res_status_reg;
            out_data_reg.granted_index <= res_idx_reg;
            out_data_reg.used_count    <= claimed_reg;
        end
    end

    assign out_data  = out_data_reg;
    assign out_valid = out_valid_reg;

    assign sts.kind       = kind_reg;
    assign sts.cnt_zero   = eff_cnt == '0;
    assign sts.idx_absent = idx_reg >= eff_cnt;
    assign sts.ts_zero_e1 = mode_reg && ts_reg == '0;
    assign sts.hit        = hit;
    assign sts.scan_last  = TSQ_W'(scan_ts_reg) == last_ts_reg;
    assign sts.out_free   = !out_valid_reg || out_ready;

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(claimed_reg) <= MAX_EP)
        else $error("claimed counter beyond endpoint total");

    a_count_moves_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.commit |=> $stable(claimed_reg))
        else $error("claimed counter moved outside write-back");

    a_fail_grants_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.status != STAT_OK |-> out_data_reg.granted_index == '0)
        else $error("failed request carries a granted index");

endmodule

`default_nettype wire
